// ===== rtl/gse_pkg.sv =====
// Shared types and constants for the granular synthesis grain engine.
// Used by gse_ctrl, gse_datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package gse_pkg;

	// Pool and table sizes.
	localparam int MAX_GRAINS  = 64;
	localparam int SLOT_W      = 6;
	localparam int TABLE_DEPTH = 16384;
	localparam int TADDR_W     = 14;
	localparam int LEN_W       = 15;

	// Iteration counts of the envelope divider and the position modulo unit.
	localparam int DIV_STEPS = 17;
	localparam int MOD_STEPS = 19;

	// Command codes carried on the input tuser.
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// Kind of result placed in the output register.
	localparam logic [1:0] RES_ZERO = 2'd0;
	localparam logic [1:0] RES_DROP = 2'd1;
	localparam logic [1:0] RES_TICK = 2'd2;

	// One input beat, unpacked.
	typedef struct packed {
		logic [TADDR_W-1:0] table_addr;
		logic signed [15:0] table_value;
		logic [29:0]        start_position;
		logic [19:0]        grain_duration;
		logic signed [20:0] grain_rate;
		logic [15:0]        grain_amplitude;
		logic [16:0]        grain_pan;
		logic [16:0]        envelope_peak;
		logic [19:0]        start_delay;
	} in_t;

	// State of one grain slot as held in the slot memory.
	typedef struct packed {
		logic [29:0]        position;
		logic signed [20:0] step;
		logic [19:0]        length;
		logic [19:0]        elapsed;
		logic [15:0]        gain;
		logic [16:0]        share;
		logic [16:0]        peak;
		logic [19:0]        delay;
	} slot_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              latch_in;
		logic              tbl_wr;
		logic [SLOT_W-1:0] slot;
		logic              slot_rd;
		logic              find_wr;
		logic              clr_active;
		logic              delay_dec;
		logic              prep;
		logic              div_start;
		logic              tbl_rd;
		logic              mul1;
		logic              mul2;
		logic              mul3;
		logic              acc;
		logic              adv_wr;
		logic              acc_clr;
		logic              out_load;
		logic [1:0]        out_kind;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic active;
		logic ended;
		logic delayed;
		logic last_after;
		logic div_done;
		logic mod_done;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/gse_ctrl.sv =====
// Controller state machine of the grain engine: sequences loads, slot
// search for starts and the per-slot tick walk. Depends on gse_pkg.
`timescale 1ns / 1ps

module gse_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     command,
	input  gse_pkg::stat_t stat,
	output gse_pkg::cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LOAD = 4'd1;
	localparam logic [3:0] ST_FIND = 4'd2;
	localparam logic [3:0] ST_RD   = 4'd3;
	localparam logic [3:0] ST_LAT  = 4'd4;
	localparam logic [3:0] ST_PK   = 4'd5;
	localparam logic [3:0] ST_DIV  = 4'd6;
	localparam logic [3:0] ST_TRD  = 4'd7;
	localparam logic [3:0] ST_MUL2 = 4'd8;
	localparam logic [3:0] ST_MUL3 = 4'd9;
	localparam logic [3:0] ST_ACC  = 4'd10;
	localparam logic [3:0] ST_DONE = 4'd11;

	localparam logic [gse_pkg::SLOT_W-1:0] LAST_SLOT = gse_pkg::SLOT_W'(gse_pkg::MAX_GRAINS - 1);

	logic [3:0]                 state_q, state_d;
	logic [gse_pkg::SLOT_W-1:0] slot_q, slot_d;
	logic [1:0]                 kind_q, kind_d;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d      = state_q;
		slot_d       = slot_q;
		kind_d       = kind_q;
		cmd          = '0;
		cmd.slot     = slot_q;
		cmd.out_kind = kind_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					slot_d       = '0;
					kind_d       = gse_pkg::RES_ZERO;
					unique case (command)
						gse_pkg::CMD_LOAD:  state_d = ST_LOAD;
						gse_pkg::CMD_START: state_d = ST_FIND;
						gse_pkg::CMD_TICK: begin
							cmd.acc_clr = 1'b1;
							kind_d      = gse_pkg::RES_TICK;
							state_d     = ST_RD;
						end
						default:            state_d = ST_DONE;
					endcase
				end
			end
			ST_LOAD: begin
				cmd.tbl_wr = 1'b1;
				state_d    = ST_DONE;
			end
			ST_FIND: begin
				if (!stat.active) begin
					cmd.find_wr = 1'b1;
					state_d     = ST_DONE;
				end else if (slot_q == LAST_SLOT) begin
					kind_d  = gse_pkg::RES_DROP;
					state_d = ST_DONE;
				end else begin
					slot_d = slot_q + 1'b1;
				end
			end
			ST_RD: begin
				if (stat.active) begin
					cmd.slot_rd = 1'b1;
					state_d     = ST_LAT;
				end else if (slot_q == LAST_SLOT) begin
					state_d = ST_DONE;
				end else begin
					slot_d = slot_q + 1'b1;
				end
			end
			ST_LAT: begin
				if (stat.ended || stat.delayed) begin
					cmd.clr_active = stat.ended;
					cmd.delay_dec  = !stat.ended;
					if (slot_q == LAST_SLOT) begin
						state_d = ST_DONE;
					end else begin
						slot_d  = slot_q + 1'b1;
						state_d = ST_RD;
					end
				end else begin
					cmd.prep = 1'b1;
					state_d  = ST_PK;
				end
			end
			ST_PK: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_done && stat.mod_done) begin
					cmd.tbl_rd = 1'b1;
					state_d    = ST_TRD;
				end
			end
			ST_TRD: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_MUL3;
			end
			ST_MUL3: begin
				cmd.mul3 = 1'b1;
				state_d  = ST_ACC;
			end
			ST_ACC: begin
				if (stat.mod_done) begin
					cmd.acc        = 1'b1;
					cmd.adv_wr     = 1'b1;
					cmd.clr_active = stat.last_after;
					if (slot_q == LAST_SLOT) begin
						state_d = ST_DONE;
					end else begin
						slot_d  = slot_q + 1'b1;
						state_d = ST_RD;
					end
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
			kind_q  <= gse_pkg::RES_ZERO;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
			kind_q  <= kind_d;
		end
	end

endmodule

// ===== rtl/gse_datapath.sv =====
// Datapath of the grain engine: sample table, slot memory, envelope divider,
// position modulo unit, gain and pan multipliers, mix accumulators and the
// output register. Depends on gse_pkg.
`timescale 1ns / 1ps

module gse_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gse_pkg::in_t               in_data,
	input  logic                       cfg_wr_en,
	input  logic [gse_pkg::LEN_W-1:0]  cfg_wr_data,
	input  gse_pkg::cmd_t              cmd,
	output gse_pkg::stat_t             stat,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic signed [15:0]         left_sample,
	output logic signed [15:0]         right_sample,
	output logic                       status
);

	localparam int ACC_W = 56;

	// Table length register and its clamped form.
	logic [gse_pkg::LEN_W-1:0] len_cfg_q;
	logic [gse_pkg::LEN_W-1:0] len_eff;
	logic [30:0]               modulus;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q <= gse_pkg::LEN_W'(gse_pkg::TABLE_DEPTH);
		end else if (cfg_wr_en) begin
			len_cfg_q <= cfg_wr_data;
		end
	end

	always_comb begin
		if (len_cfg_q == '0) begin
			len_eff = gse_pkg::LEN_W'(1);
		end else if (len_cfg_q > gse_pkg::LEN_W'(gse_pkg::TABLE_DEPTH)) begin
			len_eff = gse_pkg::LEN_W'(gse_pkg::TABLE_DEPTH);
		end else begin
			len_eff = len_cfg_q;
		end
	end

	assign modulus = {len_eff, 16'd0};

	// Latched input beat.
	gse_pkg::in_t in_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			in_q <= in_data;
		end
	end

	// Sample table.
	logic signed [15:0] sample_table [gse_pkg::TABLE_DEPTH];
	logic signed [15:0] tdat_q;
	logic [29:0]        md_v_q;

	always_ff @(posedge clk) begin
		if (cmd.tbl_wr) begin
			sample_table[in_q.table_addr] <= in_q.table_value;
		end
		if (cmd.tbl_rd) begin
			tdat_q <= sample_table[md_v_q[29:16]];
		end
	end

	// Active flags, one per slot.
	logic [gse_pkg::MAX_GRAINS-1:0] active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cmd.find_wr) begin
			active_q[cmd.slot] <= 1'b1;
		end else if (cmd.clr_active) begin
			active_q[cmd.slot] <= 1'b0;
		end
	end

	// Slot memory with registered read.
	gse_pkg::slot_t slot_mem [gse_pkg::MAX_GRAINS];
	gse_pkg::slot_t rd_q;
	gse_pkg::slot_t new_slot;
	gse_pkg::slot_t wr_slot;
	logic           mem_we;

	always_comb begin
		new_slot.position = in_q.start_position;
		new_slot.step     = in_q.grain_rate;
		new_slot.length   = in_q.grain_duration;
		new_slot.elapsed  = '0;
		new_slot.gain     = (in_q.grain_amplitude > 16'd32768) ? 16'd32768
		                                                        : in_q.grain_amplitude;
		new_slot.share    = (in_q.grain_pan > 17'd65536) ? 17'd65536 : in_q.grain_pan;
		new_slot.peak     = (in_q.envelope_peak > 17'd65536) ? 17'd65536
		                                                      : in_q.envelope_peak;
		new_slot.delay    = in_q.start_delay;
	end

	always_comb begin
		wr_slot = rd_q;
		mem_we  = cmd.find_wr || cmd.delay_dec || cmd.adv_wr;
		if (cmd.find_wr) begin
			wr_slot = new_slot;
		end else if (cmd.delay_dec) begin
			wr_slot.delay = rd_q.delay - 1'b1;
		end else begin
			wr_slot.position = md_v_q;
			wr_slot.elapsed  = rd_q.elapsed + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[cmd.slot] <= wr_slot;
		end
		if (cmd.slot_rd) begin
			rd_q <= slot_mem[cmd.slot];
		end
	end

	// Peak point in Q.16 ticks.
	logic [36:0] peak_s1;

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			peak_s1 <= rd_q.length * rd_q.peak;
		end
	end

	// Envelope divider: floor(num * 2^32 / den), one quotient bit a cycle.
	logic [35:0] tq;
	logic [19:0] dv_num;
	logic [36:0] dv_den;
	logic [36:0] dv_r_q;
	logic [36:0] dv_d_q;
	logic [16:0] dv_q_q;
	logic [4:0]  dv_cnt_q;
	logic        dv_busy_q;
	logic        dv_zero_q;
	logic [37:0] dv_trial;
	logic [16:0] env;

	assign tq = {rd_q.elapsed, 16'd0};

	always_comb begin
		if ({1'b0, tq} < peak_s1) begin
			dv_num = rd_q.elapsed;
			dv_den = peak_s1;
		end else begin
			dv_num = rd_q.length - rd_q.elapsed;
			dv_den = {1'b0, rd_q.length, 16'd0} - peak_s1;
		end
	end

	assign dv_trial = {dv_r_q, 1'b0};
	assign env      = dv_zero_q ? 17'd0 : dv_q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			dv_cnt_q  <= '0;
		end else if (cmd.div_start) begin
			dv_busy_q <= 1'b1;
			dv_cnt_q  <= 5'(gse_pkg::DIV_STEPS - 1);
		end else if (dv_busy_q) begin
			dv_cnt_q <= dv_cnt_q - 1'b1;
			if (dv_cnt_q == '0) begin
				dv_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dv_r_q    <= {2'd0, dv_num, 15'd0};
			dv_d_q    <= dv_den;
			dv_q_q    <= '0;
			dv_zero_q <= (dv_den == '0);
		end else if (dv_busy_q) begin
			if (dv_trial >= {1'b0, dv_d_q}) begin
				dv_r_q <= 37'(dv_trial - {1'b0, dv_d_q});
				dv_q_q <= {dv_q_q[15:0], 1'b1};
			end else begin
				dv_r_q <= dv_trial[36:0];
				dv_q_q <= {dv_q_q[15:0], 1'b0};
			end
		end
	end

	// Position modulo unit: restoring reduction by the table modulus.
	logic [34:0] adv_v;
	logic [34:0] md_r_q;
	logic [48:0] md_d_q;
	logic [4:0]  md_cnt_q;
	logic        md_busy_q;

	assign adv_v = {5'd0, rd_q.position} + {{14{rd_q.step[20]}}, rd_q.step}
	               + {modulus, 4'd0};
	assign md_v_q = md_r_q[29:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			md_busy_q <= 1'b0;
			md_cnt_q  <= '0;
		end else if (cmd.prep || cmd.mul1) begin
			md_busy_q <= 1'b1;
			md_cnt_q  <= 5'(gse_pkg::MOD_STEPS - 1);
		end else if (md_busy_q) begin
			md_cnt_q <= md_cnt_q - 1'b1;
			if (md_cnt_q == '0) begin
				md_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			md_r_q <= {5'd0, rd_q.position};
			md_d_q <= {modulus, 18'd0};
		end else if (cmd.mul1) begin
			md_r_q <= adv_v;
			md_d_q <= {modulus, 18'd0};
		end else if (md_busy_q) begin
			if ({14'd0, md_r_q} >= md_d_q) begin
				md_r_q <= md_r_q - md_d_q[34:0];
			end
			md_d_q <= {1'b0, md_d_q[48:1]};
		end
	end

	// Gain, envelope and pan products in registered stages: gain first, then envelope, then both pan products.
	logic signed [32:0] a_prod;
	logic signed [32:0] a_s1;
	logic signed [50:0] b_prod;
	logic signed [30:0] b_s2;
	logic [16:0]        left_share;
	logic signed [48:0] l_prod;
	logic signed [48:0] r_prod;
	logic signed [47:0] l_s3;
	logic signed [47:0] r_s3;

	assign a_prod     = tdat_q * $signed({1'b0, rd_q.gain});
	assign b_prod     = a_s1 * $signed({1'b0, env});
	assign left_share = 17'(17'd65536 - rd_q.share);
	assign l_prod     = b_s2 * $signed({1'b0, left_share});
	assign r_prod     = b_s2 * $signed({1'b0, rd_q.share});

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			a_s1 <= a_prod;
		end
		if (cmd.mul2) begin
			b_s2 <= b_prod[46:16];
		end
		if (cmd.mul3) begin
			l_s3 <= l_prod[47:0];
			r_s3 <= r_prod[47:0];
		end
	end

	// Mix accumulators.
	logic signed [ACC_W-1:0] acc_l_q;
	logic signed [ACC_W-1:0] acc_r_q;

	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			acc_l_q <= '0;
			acc_r_q <= '0;
		end else if (cmd.acc) begin
			acc_l_q <= acc_l_q + {{(ACC_W-48){l_s3[47]}}, l_s3};
			acc_r_q <= acc_r_q + {{(ACC_W-48){r_s3[47]}}, r_s3};
		end
	end

	// Scale down by 2^31 and saturate to 16 bits.
	function automatic logic signed [15:0] sat16(input logic signed [ACC_W-32:0] v);
		logic signed [15:0] res;
		if (v > $signed((ACC_W-31)'(32767))) begin
			res = 16'sd32767;
		end else if (v < -$signed((ACC_W-31)'(32768))) begin
			res = -16'sd32768;
		end else begin
			res = v[15:0];
		end
		return res;
	endfunction

	// Output register.
	logic signed [15:0] left_q;
	logic signed [15:0] right_q;
	logic               status_q;
	logic               out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			unique case (cmd.out_kind)
				gse_pkg::RES_TICK: begin
					left_q   <= sat16(acc_l_q[ACC_W-1:31]);
					right_q  <= sat16(acc_r_q[ACC_W-1:31]);
					status_q <= 1'b0;
				end
				gse_pkg::RES_DROP: begin
					left_q   <= '0;
					right_q  <= '0;
					status_q <= 1'b1;
				end
				default: begin
					left_q   <= '0;
					right_q  <= '0;
					status_q <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign left_sample  = left_q;
	assign right_sample = right_q;
	assign status       = status_q;

	// Status toward the controller.
	always_comb begin
		stat.active     = active_q[cmd.slot];
		stat.ended      = (rd_q.elapsed >= rd_q.length);
		stat.delayed    = (rd_q.delay != '0);
		stat.last_after = ({1'b0, rd_q.elapsed} + 21'd1 >= {1'b0, rd_q.length});
		stat.div_done   = !dv_busy_q;
		stat.mod_done   = !md_busy_q;
		stat.out_free   = !out_valid_q || out_ready;
	end

endmodule

// ===== rtl/granular_synth_grain_engine_top.sv =====
// Top level of the granular synthesis grain engine: stream ports,
// controller and datapath. Depends on gse_pkg, gse_ctrl and gse_datapath.
// Usage: each input beat is one command, selected by s_tuser (load a table
// word, start a grain, tick). Every command returns exactly one output beat:
// on a tick the saturated stereo mix, otherwise zero samples, with m_tuser
// set when a start found no free slot among the 64 grain slots.
// cfg_wr_en writes the table length; write it only while the block is idle.
// Sequence: a load writes one table word. A start searches the slots in
// order from slot 0 and takes the first free one. A tick walks the slots in
// order: a free slot is skipped, a slot that is ending or delayed is freed
// or has its delay counted down, and a sounding grain runs the 19-step
// position modulo unit once for the table index and once for the advance,
// with the 17-step envelope divider hidden under the first run.
// One command is in work at a time; the next beat is accepted as soon as
// the result sits in the output register, even if it is not yet taken.
// If the receiver stalls, the finished result waits in the output
// register and the following command holds before delivering its result.
// Reset marks all grain slots free and sets the table length to 16384; the
// sample table is not cleared and must be loaded before it is played.
`timescale 1ns / 1ps

module granular_synth_grain_engine_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata: table_addr[13:0], table_value[29:14], start_position[59:30],
	// grain_duration[79:60], grain_rate[100:80], grain_amplitude[116:101],
	// grain_pan[133:117], envelope_peak[150:134], start_delay[170:151], zero fill
	input  logic [175:0] s_tdata,
	// tuser: command[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: left_sample[15:0], right_sample[31:16]
	output logic [31:0]  m_tdata,
	// tuser: status[0]
	output logic [0:0]   m_tuser,
	input  logic         cfg_wr_en,
	input  logic [14:0]  cfg_wr_data
);

	gse_pkg::in_t   in_data;
	gse_pkg::cmd_t  cmd;
	gse_pkg::stat_t stat;
	logic           in_ready;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;
	logic           status;

	// Unpack the input beat.
	always_comb begin
		in_data.table_addr      = s_tdata[13:0];
		in_data.table_value     = s_tdata[29:14];
		in_data.start_position  = s_tdata[59:30];
		in_data.grain_duration  = s_tdata[79:60];
		in_data.grain_rate      = s_tdata[100:80];
		in_data.grain_amplitude = s_tdata[116:101];
		in_data.grain_pan       = s_tdata[133:117];
		in_data.envelope_peak   = s_tdata[150:134];
		in_data.start_delay     = s_tdata[170:151];
	end

	assign s_tready = in_ready;

	gse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (in_ready),
		.command  (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	gse_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_data      (in_data),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.cmd          (cmd),
		.stat         (stat),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.status       (status)
	);

	// Pack the output beat.
	assign m_tdata = {right_sample, left_sample};
	assign m_tuser = status;

endmodule
